// ----- hw/rtl/wsfd_pkg.sv -----
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5,
    PH_SKIP    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_SHORT_HDR  = 2'd1,
    ERR_SHORT_BODY = 2'd2,
    ERR_PING       = 2'd3
  } err_e;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  localparam int unsigned TDATA_W = 96;

  // Up to two results caused by one received byte, with the frame fields they share.
  typedef struct packed {
    logic        two;
    kind_e       kind_a;
    logic [7:0]  byte_a;
    err_e        err_a;
    kind_e       kind_b;
    err_e        err_b;
    logic [3:0]  opcode;
    logic        fin;
    logic [15:0] close_code;
    logic [62:0] length;
  } entry_t;

endpackage

// ----- hw/rtl/wsfd_front.sv -----
module wsfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              buffer_end_i,
  output logic              push_o,
  output wsfd_pkg::entry_t  entry_o,
  input  logic              q_full_i
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hc_q, hc_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [6:0]  short_q, short_d;
  logic [63:0] flen_q, flen_d;
  logic [31:0] key_q, key_d;
  logic [63:0] rem_q, rem_d;
  logic [1:0]  kidx_q, kidx_d;
  logic [1:0]  ccnt_q, ccnt_d;
  logic [15:0] close_q, close_d;

  logic        accept;
  logic [3:0]  ext_hdr1;
  logic [3:0]  ext_cur;
  logic [3:0]  hc_inc;
  logic [7:0]  key_byte;
  logic [7:0]  unmasked;
  logic        rem_last;
  logic        emit;
  logic        hdr_done;

  logic           have_a, have_b;
  wsfd_pkg::kind_e kind_b;
  wsfd_pkg::err_e  err_b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign ext_hdr1 = (data_byte_i[6:0] == wsfd_pkg::LEN_EXT16) ? 4'd2 :
                    (data_byte_i[6:0] == wsfd_pkg::LEN_EXT64) ? 4'd8 : 4'd0;
  assign ext_cur  = (short_q == wsfd_pkg::LEN_EXT16) ? 4'd2 :
                    (short_q == wsfd_pkg::LEN_EXT64) ? 4'd8 : 4'd0;
  assign hc_inc   = hc_q + 4'd1;
  assign rem_last = (rem_q == 64'd1);
  assign emit     = (opcode_q == wsfd_pkg::OP_CONT) || (opcode_q == wsfd_pkg::OP_TEXT) ||
                    (opcode_q == wsfd_pkg::OP_BINARY) || (opcode_q == wsfd_pkg::OP_CLOSE);

  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign unmasked = data_byte_i ^ key_byte;

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    hc_d     = hc_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    short_d  = short_q;
    flen_d   = flen_q;
    key_d    = key_q;
    rem_d    = rem_q;
    kidx_d   = kidx_q;
    ccnt_d   = ccnt_q;
    close_d  = close_q;
    hdr_done = 1'b0;
    if (accept) begin
      case (phase_q)
        wsfd_pkg::PH_HDR1: begin
          masked_d = data_byte_i[7];
          short_d  = data_byte_i[6:0];
          flen_d   = (data_byte_i[6:0] < wsfd_pkg::LEN_EXT16) ?
                     {57'd0, data_byte_i[6:0]} : 64'd0;
          hc_d     = 4'd0;
          if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end else if (ext_hdr1 != 4'd0) begin
            phase_d = wsfd_pkg::PH_EXTLEN;
          end else if (data_byte_i[7]) begin
            phase_d = wsfd_pkg::PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          flen_d = {flen_q[55:0], data_byte_i};
          hc_d   = hc_inc;
          if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end else if (hc_inc >= ext_cur) begin
            hc_d = 4'd0;
            if (masked_q) begin
              phase_d = wsfd_pkg::PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          key_d = {key_q[23:0], data_byte_i};
          hc_d  = hc_inc;
          if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end else if (hc_inc >= wsfd_pkg::KEY_BYTES) begin
            hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          if (opcode_q == wsfd_pkg::OP_CLOSE) begin
            if (ccnt_q == 2'd0) begin
              close_d = {unmasked, 8'd0};
            end else if (ccnt_q == 2'd1) begin
              close_d = {close_q[15:8], unmasked};
            end
          end
          kidx_d = kidx_q + 2'd1;
          ccnt_d = (ccnt_q == 2'd2) ? 2'd2 : ccnt_q + 2'd1;
          rem_d  = rem_q - 64'd1;
          if (rem_last) begin
            phase_d = buffer_end_i ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_SKIP;
          end else if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end
        end
        wsfd_pkg::PH_TRAILER: begin
          phase_d = buffer_end_i ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_SKIP;
        end
        wsfd_pkg::PH_SKIP: begin
          if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end
        end
        default: begin
          fin_d    = data_byte_i[7];
          opcode_d = data_byte_i[3:0];
          masked_d = 1'b0;
          short_d  = 7'd0;
          flen_d   = 64'd0;
          key_d    = 32'd0;
          kidx_d   = 2'd0;
          ccnt_d   = 2'd0;
          close_d  = 16'd0;
          hc_d     = 4'd0;
          if (buffer_end_i) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end else if (data_byte_i[3:0] == wsfd_pkg::OP_PONG) begin
            phase_d = wsfd_pkg::PH_SKIP;
          end else begin
            phase_d = wsfd_pkg::PH_HDR1;
          end
        end
      endcase
      if (hdr_done) begin
        hc_d    = 4'd0;
        kidx_d  = 2'd0;
        ccnt_d  = 2'd0;
        rem_d   = flen_d;
        phase_d = (flen_d == 64'd0) ? wsfd_pkg::PH_TRAILER : wsfd_pkg::PH_PAYLOAD;
      end
    end
  end

  // Results of the accepted byte.
  always_comb begin
    have_a = 1'b0;
    have_b = 1'b0;
    kind_b = wsfd_pkg::KIND_ERROR;
    err_b  = wsfd_pkg::ERR_NONE;
    case (phase_q)
      wsfd_pkg::PH_PAYLOAD: begin
        have_a = emit;
        if (rem_last) begin
          if (emit) begin
            have_b = 1'b1;
            kind_b = wsfd_pkg::KIND_DONE;
          end else if (opcode_q == wsfd_pkg::OP_PING) begin
            have_b = 1'b1;
            err_b  = wsfd_pkg::ERR_PING;
          end
        end else if (buffer_end_i) begin
          have_b = 1'b1;
          err_b  = wsfd_pkg::ERR_SHORT_BODY;
        end
      end
      wsfd_pkg::PH_TRAILER: begin
        if (emit) begin
          have_b = 1'b1;
          kind_b = wsfd_pkg::KIND_DONE;
        end else if (opcode_q == wsfd_pkg::OP_PING) begin
          have_b = 1'b1;
          err_b  = wsfd_pkg::ERR_PING;
        end
      end
      wsfd_pkg::PH_SKIP: begin
        have_b = 1'b0;
      end
      default: begin
        if (buffer_end_i) begin
          have_b = 1'b1;
          err_b  = wsfd_pkg::ERR_SHORT_HDR;
        end
      end
    endcase
  end

  always_comb begin
    entry_o.two        = have_a && have_b;
    entry_o.kind_a     = have_a ? wsfd_pkg::KIND_PAYLOAD : kind_b;
    entry_o.byte_a     = have_a ? unmasked : 8'd0;
    entry_o.err_a      = have_a ? wsfd_pkg::ERR_NONE : err_b;
    entry_o.kind_b     = kind_b;
    entry_o.err_b      = err_b;
    entry_o.opcode     = opcode_d;
    entry_o.fin        = fin_d;
    entry_o.close_code = (opcode_d == wsfd_pkg::OP_CLOSE) ? close_d : 16'd0;
    entry_o.length     = flen_d[62:0];
  end

  assign push_o = accept && (have_a || have_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_HDR0;
      hc_q     <= 4'd0;
      fin_q    <= 1'b0;
      opcode_q <= 4'd0;
      masked_q <= 1'b0;
      short_q  <= 7'd0;
      flen_q   <= 64'd0;
      key_q    <= 32'd0;
      rem_q    <= 64'd0;
      kidx_q   <= 2'd0;
      ccnt_q   <= 2'd0;
      close_q  <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      hc_q     <= hc_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      short_q  <= short_d;
      flen_q   <= flen_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      kidx_q   <= kidx_d;
      ccnt_q   <= ccnt_d;
      close_q  <= close_d;
    end
  end

endmodule

// ----- hw/rtl/wsfd_queue.sv -----
module wsfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsfd_pkg::entry_t  wr_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wsfd_pkg::entry_t  rd_data_o
);

  wsfd_pkg::entry_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign rd_data_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- hw/rtl/wsfd_back.sv -----
module wsfd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  wsfd_pkg::entry_t                q_data_i,
  output logic                            pop_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [wsfd_pkg::TDATA_W-1:0]    m_tdata_o,
  output logic [1:0]                      m_tuser_o,
  output logic                            m_tlast_o
);

  wsfd_pkg::entry_t cur_q, cur_d;
  logic valid_q, valid_d;
  logic sel_q, sel_d;
  logic accept, done_entry, load;
  logic [7:0]      out_byte;
  wsfd_pkg::kind_e out_kind;
  wsfd_pkg::err_e  out_err;

  assign accept     = valid_q && m_tready_i;
  assign done_entry = accept && (sel_q || !cur_q.two);
  assign load       = (!valid_q || done_entry) && q_valid_i;
  assign pop_o      = load;

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      cur_d   = q_data_i;
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end else if (done_entry) begin
      valid_d = 1'b0;
    end else if (accept) begin
      sel_d = 1'b1;
    end
  end

  assign out_kind = sel_q ? cur_q.kind_b : cur_q.kind_a;
  assign out_err  = sel_q ? cur_q.err_b : cur_q.err_a;
  assign out_byte = sel_q ? 8'd0 : cur_q.byte_a;

  assign m_tvalid_o = valid_q;
  assign m_tuser_o  = out_kind;
  assign m_tlast_o  = sel_q || !cur_q.two;
  assign m_tdata_o  = {2'b00, out_err, cur_q.length, cur_q.close_code, cur_q.fin,
                       cur_q.opcode, out_byte};

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// ----- hw/rtl/websocket_frame_deframer_top.sv -----
// Channel   Direction  tdata                                  tuser        tlast
// s_axis    in         [7:0] data_byte                        -            buffer_end
// m_axis    out        [7:0] payload_byte, [11:8] frame_opcode, [1:0]        last
//                      [12] final_flag, [28:13] close_code,   result_kind
//                      [91:29] payload_length, [93:92] error_code
//
// One received byte is taken per cycle while the queue is not full; its first result is written
// into the queue and then into the output register, which shows it on m_axis.
// A byte that causes two results (a payload byte with completion or error) holds the output port
// for both, so the output port, at one result per cycle unless stalled, sets the sustained rate.
// A two-entry queue between the parser and the output stage lets either side stall alone.
// Reset puts the parser at the start of a frame header with an empty queue and no result shown.
module websocket_frame_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // data_byte
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // payload_byte, frame_opcode, final_flag, close_code, payload_length, error_code, zero pad
  output logic [wsfd_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic [1:0]                    m_axis_tuser_o,  // result_kind
  output logic                          m_axis_tlast_o
);

  wsfd_pkg::entry_t push_entry, pop_entry;
  logic q_push, q_full, q_pop, q_valid;

  wsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i),
    .buffer_end_i (s_axis_tlast_i),
    .push_o       (q_push),
    .entry_o      (push_entry),
    .q_full_i     (q_full)
  );

  wsfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (push_entry),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (pop_entry)
  );

  wsfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_entry),
    .pop_o      (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  // The parser never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue written while full");

  // A payload byte result carries no error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == wsfd_pkg::KIND_PAYLOAD))
      |-> (m_axis_tdata_o[93:92] == wsfd_pkg::ERR_NONE))
    else $error("payload result with error code");

  // An error or completion is always the last result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != wsfd_pkg::KIND_PAYLOAD)) |-> m_axis_tlast_o)
    else $error("error or completion result not marked last");

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 550;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned N_ROWS       = 25;
  localparam int unsigned PAYLOAD_CAP  = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       buf_end;
    logic       typed;
    kind_e      kind;
    err_e       err;
  } stim_row_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pbyte;
    logic [3:0]  opcode;
    logic        fin;
    logic [15:0] close_code;
    logic [62:0] length;
    err_e        err;
    logic        last;
  } frame_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = 8'h00;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  websocket_frame_deframer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Parser state as the deframer should hold it.
  phase_e      phase;
  logic [3:0]  hdr_cnt;
  logic        fin_q;
  logic [3:0]  opc_q;
  logic        masked_q;
  logic [6:0]  short_len;
  logic [63:0] frame_len;
  logic [31:0] key_q;
  logic [63:0] pay_cnt;
  logic [15:0] close_st;

  frame_result_t step_q[$];
  frame_result_t expected_q[$];
  logic [7:0]    buffer_q[$];

  int unsigned cycle_cnt = 0;
  int          fail_cnt  = 0;
  logic        tx_burst  = 1'b0;
  logic        rx_burst  = 1'b0;
  logic        hold_req  = 1'b0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{8'h8A, 1'b1, 1'b1, KIND_ERROR,   ERR_SHORT_HDR},
    '{8'h8A, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'hFF, 1'b1, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h89, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h00, 1'b1, 1'b1, KIND_ERROR,   ERR_PING},
    '{8'h88, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'hFF, 1'b1, 1'b1, KIND_DONE,    ERR_NONE},
    '{8'h02, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h7E, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h03, 1'b1, 1'b1, KIND_ERROR,   ERR_SHORT_HDR},
    '{8'h83, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h02, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h55, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h66, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h00, 1'b1, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h85, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h00, 1'b1, 1'b1, KIND_ERROR,   ERR_SHORT_HDR},
    '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'h03, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE},
    '{8'hAB, 1'b1, 1'b1, KIND_ERROR,   ERR_SHORT_BODY}
  };

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic is_data_frame();
    return opc_q == OP_CONT || opc_q == OP_TEXT || opc_q == OP_BINARY || opc_q == OP_CLOSE;
  endfunction

  function automatic int ext_len_bytes();
    if (short_len == LEN_EXT16) return 2;
    if (short_len == LEN_EXT64) return 8;
    return 0;
  endfunction

  function automatic void post(kind_e k, logic [7:0] b, err_e e);
    frame_result_t r;
    r.kind       = k;
    r.pbyte      = b;
    r.opcode     = opc_q;
    r.fin        = fin_q;
    r.close_code = (opc_q == OP_CLOSE) ? close_st : 16'h0000;
    r.length     = frame_len[62:0];
    r.err        = e;
    r.last       = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void start_payload();
    hdr_cnt = 4'd0;
    pay_cnt = 64'd0;
    phase   = (frame_len == 64'd0) ? PH_TRAILER : PH_PAYLOAD;
  endfunction

  function automatic void close_frame(logic e);
    if (is_data_frame()) post(KIND_DONE, 8'h00, ERR_NONE);
    else if (opc_q == OP_PING) post(KIND_ERROR, 8'h00, ERR_PING);
    phase = e ? PH_HDR0 : PH_SKIP;
  endfunction

  function automatic void short_header();
    post(KIND_ERROR, 8'h00, ERR_SHORT_HDR);
    phase = PH_HDR0;
  endfunction

  function automatic void reset_parser();
    phase     = PH_HDR0;
    hdr_cnt   = 4'd0;
    fin_q     = 1'b0;
    opc_q     = 4'd0;
    masked_q  = 1'b0;
    short_len = 7'd0;
    frame_len = 64'd0;
    key_q     = 32'd0;
    pay_cnt   = 64'd0;
    close_st  = 16'h0000;
  endfunction

  function automatic void advance_parser(logic [7:0] b, logic e);
    logic [7:0] plain;
    plain = b ^ key_q[8 * (3 - int'(pay_cnt[1:0])) +: 8];
    case (phase)
      PH_HDR1: begin
        masked_q  = b[7];
        short_len = b[6:0];
        frame_len = (b[6:0] < LEN_EXT16) ? {57'd0, b[6:0]} : 64'd0;
        hdr_cnt   = 4'd0;
        if (e) short_header();
        else if (ext_len_bytes() != 0) phase = PH_EXTLEN;
        else if (masked_q) phase = PH_KEY;
        else start_payload();
      end
      PH_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        hdr_cnt   = hdr_cnt + 4'd1;
        if (e) begin
          short_header();
        end else if (int'(hdr_cnt) >= ext_len_bytes()) begin
          hdr_cnt = 4'd0;
          if (masked_q) phase = PH_KEY;
          else start_payload();
        end
      end
      PH_KEY: begin
        key_q   = {key_q[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (e) short_header();
        else if (hdr_cnt >= KEY_BYTES) start_payload();
      end
      PH_PAYLOAD: begin
        if (opc_q == OP_CLOSE) begin
          if (pay_cnt == 64'd0) close_st = {plain, 8'h00};
          else if (pay_cnt == 64'd1) close_st[7:0] = plain;
        end
        if (is_data_frame()) post(KIND_PAYLOAD, plain, ERR_NONE);
        pay_cnt = pay_cnt + 64'd1;
        if (pay_cnt == frame_len) begin
          close_frame(e);
        end else if (e) begin
          post(KIND_ERROR, 8'h00, ERR_SHORT_BODY);
          phase = PH_HDR0;
        end
      end
      PH_TRAILER: close_frame(e);
      PH_SKIP: begin
        if (e) phase = PH_HDR0;
      end
      default: begin
        reset_parser();
        fin_q = b[7];
        opc_q = b[3:0];
        if (e) short_header();
        else phase = (opc_q == OP_PONG) ? PH_SKIP : PH_HDR1;
      end
    endcase
  endfunction

  function automatic void commit_step();
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
    step_q.delete();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = e;
    do @(posedge clk_i); while (!s_axis_tready_o);
    advance_parser(b, e);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic build_buffer();
    logic [3:0]  opc;
    logic [6:0]  code;
    logic [63:0] len;
    logic        mask;
    logic [31:0] key;
    int          nbytes;
    int          cut;
    buffer_q.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 12)) buffer_q.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 9))
      0:       opc = OP_CONT;
      1, 2, 9: opc = OP_TEXT;
      3:       opc = OP_BINARY;
      4, 5:    opc = OP_CLOSE;
      6:       opc = OP_PING;
      7:       opc = OP_PONG;
      default: opc = 4'($urandom);
    endcase
    buffer_q.push_back({1'($urandom), 3'($urandom), opc});
    mask = 1'($urandom);
    key  = $urandom;
    case ($urandom_range(0, 9))
      6, 7: begin
        len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                           : 64'($urandom_range(0, 40));
        code = LEN_EXT16;
      end
      8: begin
        len  = 64'($urandom_range(0, 40));
        code = LEN_EXT64;
      end
      9: begin
        len  = {$urandom, $urandom};
        code = LEN_EXT64;
      end
      default: begin
        len  = 64'($urandom_range(0, 20));
        code = len[6:0];
      end
    endcase
    buffer_q.push_back({mask, code});
    if (code == LEN_EXT16) begin
      buffer_q.push_back(len[15:8]);
      buffer_q.push_back(len[7:0]);
    end else if (code == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) buffer_q.push_back(len[8 * i +: 8]);
    end
    if (mask) begin
      for (int i = 3; i >= 0; i--) buffer_q.push_back(key[8 * i +: 8]);
    end
    nbytes = (len > 64'(PAYLOAD_CAP)) ? $urandom_range(0, PAYLOAD_CAP) : int'(len);
    repeat (nbytes) buffer_q.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) buffer_q.push_back(8'($urandom));
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, buffer_q.size());
      while (buffer_q.size() > cut) void'(buffer_q.pop_back());
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result();
    frame_result_t      want;
    logic [TDATA_W-1:0] d;
    d = m_axis_tdata_o;
    if (expected_q.size() == 0) begin
      $error("unexpected transfer: tuser 0x%0h, tdata 0x%0h", m_axis_tuser_o, d);
      fail_cnt++;
    end else begin
      want = expected_q.pop_front();
      check_field("result_kind", 64'(want.kind), 64'(m_axis_tuser_o));
      check_field("payload_byte", 64'(want.pbyte), 64'(d[7:0]));
      check_field("frame_opcode", 64'(want.opcode), 64'(d[11:8]));
      check_field("final_flag", 64'(want.fin), 64'(d[12]));
      check_field("close_code", 64'(want.close_code), 64'(d[28:13]));
      check_field("payload_length", 64'(want.length), 64'(d[91:29]));
      check_field("error_code", 64'(want.err), 64'(d[93:92]));
      check_field("tdata_pad", 64'd0, 64'(d[TDATA_W-1:94]));
      check_field("last", 64'(want.last), 64'(m_axis_tlast_o));
    end
  endtask

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_result();
    end
  end

  initial begin
    stim_row_t   row;
    int unsigned sent;
    int unsigned nbuf;
    reset_parser();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      send_byte(row.data, row.buf_end);
      if (row.typed) begin
        if (step_q.size() == 0) begin
          post(row.kind, 8'h00, row.err);
        end else begin
          step_q[step_q.size() - 1].kind = row.kind;
          step_q[step_q.size() - 1].err  = row.err;
        end
      end
      commit_step();
    end
    wait_drained();

    sent = 0;
    nbuf = 0;
    while (sent < RANDOM_BYTES) begin
      build_buffer();
      tx_burst = ($urandom_range(0, 3) == 0);
      foreach (buffer_q[i]) begin
        send_byte(buffer_q[i], i == buffer_q.size() - 1);
        commit_step();
      end
      sent += buffer_q.size();
      nbuf++;
      if (nbuf == 4) hold_req = 1'b1;
      if (nbuf == 30) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_front.sv
hw/rtl/wsfd_queue.sv
hw/rtl/wsfd_back.sv
hw/rtl/websocket_frame_deframer_top.sv
bench/testbench.sv
